/* rtl/core/tpsq_pkg.sv */
package tpsq_pkg;

   // Request codes
   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_REFRESH = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   // Result status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // Highest priority; also the start value of the eviction scan
   localparam logic [1:0] PRIO_MAX  = 2'd3;
   localparam logic [1:0] PRIO_IDLE = 2'd0;

   // One stored entry
   typedef struct packed {
      logic [4:0]  code;
      logic [1:0]  prio;
      logic [31:0] stamp;
      logic [15:0] life;
   } entry_type;

   // Request beat
   typedef struct packed {
      action_type  action;
      logic [4:0]  state_code;
      logic [1:0]  priority_req;
      logic [15:0] lifetime_ms;
      logic [31:0] now_ms;
   } req_payload_type;

   // Result beat
   typedef struct packed {
      logic       status;
      logic [4:0] shown_state;
      logic [1:0] shown_priority;
      logic [3:0] entry_count;
   } rsp_payload_type;

   // Config beat
   typedef struct packed {
      logic [4:0] idle_state_code;
   } csr_payload_type;

   // Flags from the shared compare unit
   typedef struct packed {
      logic expired;    // lifetime elapsed at the request time
      logic below_new;  // entry priority below the request priority
      logic below_low;  // entry priority below the lowest seen so far
   } cmp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVSCAN,
      ST_EVSHIFT,
      ST_PLACE,
      ST_REFRESH,
      ST_FINISH
   } state_type;

endpackage

/* rtl/core/tpsq_req_if.sv */
interface tpsq_req_if import tpsq_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/tpsq_rsp_if.sv */
interface tpsq_rsp_if import tpsq_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/tpsq_csr_if.sv */
interface tpsq_csr_if import tpsq_pkg::*; ();
   logic            valid;
   logic            ready;
   csr_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/tpsq_entry_store.sv */
module tpsq_entry_store import tpsq_pkg::*; #(
   parameter int DEPTH = 8,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  entry_type        wr_data
);

   // Entry file: one read and one write each cycle
   entry_type entries_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = entries_ff[rd_idx];

endmodule

/* rtl/core/tpsq_cmp_unit.sv */
module tpsq_cmp_unit import tpsq_pkg::*; (
   input  entry_type   entry,
   input  logic [31:0] now_ms,
   input  logic [1:0]  new_prio,
   input  logic [1:0]  low_prio,
   output cmp_type     flags
);

   logic [31:0] age;

   // Wrapping age against lifetime; zero lifetime never expires
   assign age = now_ms - entry.stamp;

   assign flags.expired   = (entry.life != 16'd0) && (age >= {16'd0, entry.life});
   assign flags.below_new = entry.prio < new_prio;
   assign flags.below_low = entry.prio < low_prio;

endmodule

/* rtl/core/timed_priority_status_queue.sv */
// Priority status queue with per-entry expiry. Up to QUEUE_DEPTH entries are
// kept in a small register file, sorted highest priority first, and one
// compare unit walks that file one entry per cycle under a sequencer; the
// block takes one request at a time. An insert into a full list is either
// rejected or evicts an entry. The result sits in an output register, so a
// new request is taken while it waits. The idle code register is written
// through the csr channel, which is always ready.
module timed_priority_status_queue import tpsq_pkg::*; #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   tpsq_req_if.sink    req_chan,
   tpsq_rsp_if.source  rsp_chan,
   tpsq_csr_if.sink    csr_chan
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   state_type       state_ff, state_in;
   req_payload_type item_ff, item_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] wptr_ff, wptr_in;
   logic [CNT_W-1:0] low_idx_ff, low_idx_in;
   logic [1:0]      low_prio_ff, low_prio_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [4:0]      sel_code_ff, sel_code_in;
   logic [1:0]      sel_prio_ff, sel_prio_in;
   logic            status_ff, status_in;
   logic [4:0]      idle_ff, idle_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [CNT_W-1:0] rd_cnt;
   logic [CNT_W-1:0] idx_up;
   logic [CNT_W-1:0] idx_dn;
   logic             wr_en;
   logic [CNT_W-1:0] wr_cnt;
   entry_type        wr_data;
   entry_type        ent_rd;
   entry_type        new_ent;
   cmp_type          cmp;
   logic [1:0]       low_prio_nx;
   logic [CNT_W-1:0] low_idx_nx;

   // Entry file
   tpsq_entry_store #(.DEPTH(QUEUE_DEPTH)) u_store (
      .clock   (clock),
      .rd_idx  (rd_cnt[IDX_W-1:0]),
      .rd_data (ent_rd),
      .wr_en   (wr_en),
      .wr_idx  (wr_cnt[IDX_W-1:0]),
      .wr_data (wr_data)
   );

   // Shared compare unit
   tpsq_cmp_unit u_cmp (
      .entry    (ent_rd),
      .now_ms   (item_ff.now_ms),
      .new_prio (item_ff.priority_req),
      .low_prio (low_prio_ff),
      .flags    (cmp)
   );

   assign idx_up = idx_ff + CNT_ONE;
   assign idx_dn = idx_ff - CNT_ONE;

   assign new_ent = '{code:  item_ff.state_code,
                      prio:  item_ff.priority_req,
                      stamp: item_ff.now_ms,
                      life:  item_ff.lifetime_ms};

   // Running minimum of the eviction scan
   assign low_prio_nx = cmp.below_low ? ent_rd.prio : low_prio_ff;
   assign low_idx_nx  = cmp.below_low ? idx_ff : low_idx_ff;

   // Config port
   assign csr_chan.ready = 1'b1;
   assign idle_in = csr_chan.valid ? csr_chan.payload.idle_state_code : idle_ff;

   // Result port
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      wptr_in      = wptr_ff;
      low_idx_in   = low_idx_ff;
      low_prio_in  = low_prio_ff;
      cnt_in       = cnt_ff;
      sel_code_in  = sel_code_ff;
      sel_prio_in  = sel_prio_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_in       = rsp_ff;
      rd_cnt       = idx_ff;
      wr_en        = 1'b0;
      wr_cnt       = idx_ff;
      wr_data      = ent_rd;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               item_in     = req_chan.payload;
               status_in   = STATUS_OK;
               idx_in      = '0;
               wptr_in     = '0;
               low_idx_in  = '0;
               low_prio_in = PRIO_MAX;
               unique case (req_chan.payload.action)
                  ACT_INSERT: begin
                     if (cnt_ff == CNT_FULL) begin
                        state_in = ST_EVSCAN;
                     end else begin
                        idx_in   = cnt_ff;
                        state_in = ST_PLACE;
                     end
                  end
                  ACT_REFRESH: begin
                     state_in = ST_REFRESH;
                  end
                  ACT_CLEAR: begin
                     // Empty the list, then hold idle as a permanent entry
                     wr_en       = 1'b1;
                     wr_cnt      = '0;
                     wr_data     = '{code:  idle_ff,
                                     prio:  PRIO_IDLE,
                                     stamp: req_chan.payload.now_ms,
                                     life:  16'd0};
                     cnt_in      = CNT_ONE;
                     sel_code_in = idle_ff;
                     sel_prio_in = PRIO_IDLE;
                     state_in    = ST_FINISH;
                  end
                  ACT_NONE: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_EVSCAN: begin
            // Find the first entry of lowest priority
            low_prio_in = low_prio_nx;
            low_idx_in  = low_idx_nx;
            if (idx_ff == CNT_LAST) begin
               if (item_ff.priority_req <= low_prio_nx) begin
                  status_in = STATUS_REJECT;
                  state_in  = ST_FINISH;
               end else begin
                  idx_in   = low_idx_nx;
                  state_in = ST_EVSHIFT;
               end
            end else begin
               idx_in = idx_up;
            end
         end

         ST_EVSHIFT: begin
            // Close the gap left by the evicted entry
            rd_cnt = idx_up;
            if (idx_up < cnt_ff) begin
               wr_en  = 1'b1;
               wr_cnt = idx_ff;
               idx_in = idx_up;
            end else begin
               cnt_in   = CNT_LAST;
               idx_in   = CNT_LAST;
               state_in = ST_PLACE;
            end
         end

         ST_PLACE: begin
            // Walk back from the tail, moving lower entries up by one
            rd_cnt = idx_dn;
            wr_en  = 1'b1;
            wr_cnt = idx_ff;
            if ((idx_ff != '0) && cmp.below_new) begin
               idx_in = idx_dn;
            end else begin
               wr_data  = new_ent;
               cnt_in   = cnt_ff + CNT_ONE;
               state_in = ST_FINISH;
            end
         end

         ST_REFRESH: begin
            // Compact the kept entries toward the head
            if (idx_ff == cnt_ff) begin
               cnt_in = wptr_ff;
               if (wptr_ff == '0) begin
                  sel_code_in = idle_ff;
                  sel_prio_in = PRIO_IDLE;
               end
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_up;
               if (!cmp.expired) begin
                  wr_en   = 1'b1;
                  wr_cnt  = wptr_ff;
                  wptr_in = wptr_ff + CNT_ONE;
                  if (wptr_ff == '0) begin
                     sel_code_in = ent_rd.code;
                     sel_prio_in = ent_rd.prio;
                  end
               end
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in.status         = status_ff;
               rsp_in.shown_state    = sel_code_ff;
               rsp_in.shown_priority = sel_prio_ff;
               rsp_in.entry_count    = 4'(cnt_ff);
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sel_code_ff  <= 5'd0;
         sel_prio_ff  <= PRIO_IDLE;
         idle_ff      <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_code_ff  <= sel_code_in;
         sel_prio_ff  <= sel_prio_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      idx_ff      <= idx_in;
      wptr_ff     <= wptr_in;
      low_idx_ff  <= low_idx_in;
      low_prio_ff <= low_prio_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

   // Checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("entry count above depth");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status_ff == STATUS_REJECT) |-> cnt_ff == CNT_FULL)
      else $error("insert rejected on a list that is not full");

   a_place_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLACE) |-> (cnt_ff < CNT_FULL && idx_ff <= cnt_ff))
      else $error("placement without a free slot");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REFRESH) |-> (wptr_ff <= idx_ff && idx_ff <= cnt_ff))
      else $error("refresh write pointer passed read pointer");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !rsp_valid_ff) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished result not loaded");

endmodule

/* tb/timed_priority_status_queue_checker.sv */
// Watches the request, result and idle-code channels of the status queue.
// Keeps its own copy of the sorted entry list, predicts one result beat per
// accepted request beat and compares it with the oldest one still waiting.
module timed_priority_status_queue_checker import tpsq_pkg::*; #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic clock,
   input  logic reset,
   tpsq_req_if  req_chan,
   tpsq_rsp_if  rsp_chan,
   tpsq_csr_if  csr_chan,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count,
   output int   reject_count,
   output int   evict_count,
   output int   expire_count
);

   // predicted queue contents and selection
   entry_type       slots [QUEUE_DEPTH];
   int              held;
   logic [4:0]      idle_code;
   logic [4:0]      shown_code;
   logic [1:0]      shown_prio;
   rsp_payload_type expected_status_q [$];

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   // new entry goes after every entry of equal or higher priority
   function automatic void place_entry(logic [4:0] code, logic [1:0] prio,
                                       logic [31:0] stamp, logic [15:0] life);
      int pos;
      if (held >= QUEUE_DEPTH)
         return;
      pos = held;
      for (int i = held - 1; i >= 0; i--)
         if (prio > slots[i].prio)
            pos = i;
      for (int i = held; i > pos; i--)
         slots[i] = slots[i - 1];
      slots[pos].code  = code;
      slots[pos].prio  = prio;
      slots[pos].stamp = stamp;
      slots[pos].life  = life;
      held++;
   endfunction

   // full list: drop first lowest entry, only for a strictly higher newcomer
   function automatic logic insert_entry(req_payload_type r);
      int         low_idx;
      logic [1:0] low_prio;
      if (held >= QUEUE_DEPTH) begin
         low_idx  = 0;
         low_prio = PRIO_MAX;
         for (int i = 0; i < held; i++)
            if (slots[i].prio < low_prio) begin
               low_prio = slots[i].prio;
               low_idx  = i;
            end
         if (r.priority_req <= low_prio) begin
            reject_count++;
            return STATUS_REJECT;
         end
         for (int i = low_idx; i + 1 < held; i++)
            slots[i] = slots[i + 1];
         held = QUEUE_DEPTH - 1;
         evict_count++;
      end
      place_entry(r.state_code, r.priority_req, r.now_ms, r.lifetime_ms);
      return STATUS_OK;
   endfunction

   // drop expired entries in order, then select the head
   function automatic void refresh_entries(logic [31:0] now);
      int          kept;
      logic [31:0] age;
      kept = 0;
      for (int i = 0; i < held; i++) begin
         age = now - slots[i].stamp;
         if (slots[i].life != 16'd0 && age >= {16'd0, slots[i].life}) begin
            expire_count++;
         end else begin
            slots[kept] = slots[i];
            kept++;
         end
      end
      held = kept;
      if (held == 0) begin
         shown_code = idle_code;
         shown_prio = PRIO_IDLE;
      end else begin
         shown_code = slots[0].code;
         shown_prio = slots[0].prio;
      end
   endfunction

   function automatic rsp_payload_type queue_step(req_payload_type r);
      rsp_payload_type res;
      res.status = STATUS_OK;
      case (r.action)
         ACT_INSERT: res.status = insert_entry(r);
         ACT_REFRESH: refresh_entries(r.now_ms);
         ACT_CLEAR: begin
            held = 0;
            place_entry(idle_code, PRIO_IDLE, r.now_ms, 16'd0);
            shown_code = idle_code;
            shown_prio = PRIO_IDLE;
         end
         default: ;
      endcase
      res.shown_state    = shown_code;
      res.shown_priority = shown_prio;
      res.entry_count    = held[3:0];
      return res;
   endfunction

   // result beats are compared before the same edge's request is predicted
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         held       = 0;
         idle_code  = 5'd0;
         shown_code = 5'd0;
         shown_prio = PRIO_IDLE;
         expected_status_q.delete();
         pending_count = 0;
      end else begin
         if (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1)
            idle_code = csr_chan.payload.idle_state_code;
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got = rsp_chan.payload;
            if (expected_status_q.size() == 0) begin
               note_failure($sformatf({"result beat with nothing expected:",
                            " st=%0d code=%0d pr=%0d n=%0d"},
                            got.status, got.shown_state, got.shown_priority, got.entry_count));
            end else begin
               want = expected_status_q.pop_front();
               checked_count++;
               if (got.status !== want.status || got.shown_state !== want.shown_state ||
                   got.shown_priority !== want.shown_priority ||
                   got.entry_count !== want.entry_count)
                  note_failure($sformatf({"result %0d mismatch: expected",
                               " st=%0d code=%0d pr=%0d n=%0d,",
                               " got st=%0d code=%0d pr=%0d n=%0d"}, checked_count,
                               want.status, want.shown_state, want.shown_priority,
                               want.entry_count, got.status, got.shown_state,
                               got.shown_priority, got.entry_count));
            end
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            expected_status_q.push_back(queue_step(req_chan.payload));
         pending_count = expected_status_q.size();
      end
   end

endmodule

/* tb/timed_priority_status_queue_test.sv */
// Stimulus and verdict for the status queue; checking lives in the checker.
module timed_priority_status_queue_test import tpsq_pkg::*; ();

   localparam int DEPTH       = 8;
   localparam int PHASES      = 6;
   localparam int PHASE_BEATS = 305;

   logic clock = 1'b0;
   logic reset;

   tpsq_req_if req_chan ();
   tpsq_rsp_if rsp_chan ();
   tpsq_csr_if csr_chan ();

   int fail_count;
   int pending_count;
   int checked_count;
   int reject_count;
   int evict_count;
   int expire_count;

   // stimulus bookkeeping
   int          beats_sent;
   int          idle_writes;
   int          burst_left;
   bit          no_gaps;
   bit          long_hold_request;
   logic [31:0] ms_clock;
   logic [4:0]  phase_idle_code [PHASES];

   timed_priority_status_queue #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   timed_priority_status_queue_checker #(.QUEUE_DEPTH(DEPTH)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_chan      (csr_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .reject_count  (reject_count),
      .evict_count   (evict_count),
      .expire_count  (expire_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // result side: random stall patterns, plus one long hold on request
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      rsp_chan.ready = 1'b0;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && long_hold_request) begin
            hold_left = 400;
            long_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic req_payload_type make_req(action_type act, logic [4:0] code,
                                                logic [1:0] prio, logic [15:0] dur,
                                                logic [31:0] now);
      req_payload_type p;
      p.action       = act;
      p.state_code   = code;
      p.priority_req = prio;
      p.lifetime_ms  = dur;
      p.now_ms       = now;
      return p;
   endfunction

   // drop valid for a while; returns on a later falling edge
   task automatic idle_sender(int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // offer one beat and wait for it to be taken, then maybe open a gap
   task automatic send(req_payload_type p);
      req_chan.valid   <= 1'b1;
      req_chan.payload <= p;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
      beats_sent++;
      if (!no_gaps) begin
         burst_left--;
         if (burst_left <= 0) begin
            if ($urandom_range(0, 3) != 0)
               idle_sender($urandom_range(1, 12));
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   // wait until every predicted result has come back, then let the block settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (2 * DEPTH + 4) @(negedge clock);
   endtask

   task automatic write_idle_code(logic [4:0] code);
      drain();
      csr_chan.valid <= 1'b1;
      csr_chan.payload.idle_state_code <= code;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      idle_writes++;
   endtask

   // mostly well-formed traffic on a running clock, some noise on top
   task automatic send_random_beat();
      int              pick;
      int              dur_pick;
      req_payload_type p;
      pick = $urandom_range(0, 99);
      ms_clock = ms_clock + $urandom_range(0, 40);
      p = make_req(ACT_REFRESH, 5'($urandom), 2'($urandom), 16'($urandom), ms_clock);
      if (pick < 55) begin
         p.action = ACT_INSERT;
         dur_pick = $urandom_range(0, 99);
         if (dur_pick < 35)
            p.lifetime_ms = 16'd0;
         else if (dur_pick < 80)
            p.lifetime_ms = 16'($urandom_range(1, 400));
      end else if (pick < 83) begin
         p.action = ACT_REFRESH;
      end else if (pick < 87) begin
         p.action = ACT_CLEAR;
      end else if (pick < 91) begin
         p.action = ACT_NONE;
      end else begin
         p.action = action_type'($urandom_range(0, 3));
         p.now_ms = $urandom;
      end
      send(p);
   endtask

   // edges of the fields, wrap of the clock, expiry, full lists, rejects
   task automatic send_directed();
      logic [31:0] t0;
      t0 = 32'hFFFF_FFF0;
      send(make_req(ACT_REFRESH, 5'd0, 2'd0, 16'd0, t0));
      send(make_req(ACT_NONE, 5'd31, PRIO_MAX, 16'hFFFF, 32'hFFFF_FFFF));
      send(make_req(ACT_INSERT, 5'd31, PRIO_IDLE, 16'hFFFF, t0));
      send(make_req(ACT_INSERT, 5'd0, PRIO_MAX, 16'd0, t0));
      send(make_req(ACT_INSERT, 5'd5, 2'd1, 16'd1, t0 + 1));
      // clock wraps: the one-ms entry is gone, the long one stays
      send(make_req(ACT_REFRESH, 5'd0, 2'd0, 16'd0, 32'h0000_0010));
      send(make_req(ACT_INSERT, 5'd9, 2'd2, 16'h8000, 32'h0000_0010));
      // age equal to lifetime expires
      send(make_req(ACT_REFRESH, 5'd0, 2'd0, 16'd0, 32'h0000_8010));
      send(make_req(ACT_CLEAR, 5'd3, 2'd3, 16'd7, 32'h0000_9000));
      // fill with top priority; the last one pushes out the idle entry
      for (int i = 0; i < DEPTH; i++)
         send(make_req(ACT_INSERT, 5'(10 + i), PRIO_MAX, 16'd0, 32'h0000_9000 + i));
      // full of top priority: nothing gets in
      send(make_req(ACT_INSERT, 5'd20, PRIO_MAX, 16'd0, 32'h0000_9100));
      send(make_req(ACT_INSERT, 5'd21, PRIO_IDLE, 16'd0, 32'h0000_9100));
      send(make_req(ACT_REFRESH, 5'd0, 2'd0, 16'd0, 32'd0));
      send(make_req(ACT_CLEAR, 5'd0, 2'd0, 16'd0, 32'd1));
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      csr_chan.valid = 1'b0;
      csr_chan.payload = '0;
      beats_sent = 0;
      idle_writes = 0;
      burst_left = 1;
      no_gaps = 1'b0;
      long_hold_request = 1'b0;
      ms_clock = 32'd0;
      phase_idle_code[0] = 5'd0;
      phase_idle_code[1] = 5'($urandom);
      phase_idle_code[2] = 5'd31;
      phase_idle_code[3] = 5'($urandom);
      phase_idle_code[4] = 5'd10;
      phase_idle_code[5] = 5'($urandom);
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      write_idle_code(5'd31);
      send_directed();

      for (int ph = 0; ph < PHASES; ph++) begin
         write_idle_code(phase_idle_code[ph]);
         ms_clock = (ph == 3) ? 32'hFFFF_F000 : $urandom;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // block fills while results are held back
            if (ph == 1 && n == 100) begin
               long_hold_request = 1'b1;
               no_gaps = 1'b1;
            end
            if (ph == 1 && n == 140)
               no_gaps = 1'b0;
            if (n == 150)
               drain();
            send_random_beat();
         end
      end

      drain();
      $display("Sent %0d request beats, %0d results checked, idle code written %0d times.",
               beats_sent, checked_count, idle_writes);
      $display("Saw %0d rejected inserts, %0d evictions and %0d expired entries.",
               reject_count, evict_count, expire_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/tpsq_pkg.sv
rtl/core/tpsq_req_if.sv
rtl/core/tpsq_rsp_if.sv
rtl/core/tpsq_csr_if.sv
rtl/core/tpsq_entry_store.sv
rtl/core/tpsq_cmp_unit.sv
rtl/core/timed_priority_status_queue.sv
tb/timed_priority_status_queue_checker.sv
tb/timed_priority_status_queue_test.sv
